@@ rtl/svs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package svs_pkg;

   // result layout
   localparam int AXES           = 5;
   localparam int AXIS_BITS      = 3;
   localparam int ANGLE_BITS     = 14;
   localparam int SEG_BITS       = 8;
   localparam int DIGIT_BITS     = 4;

   localparam logic [AXIS_BITS-1:0] AXIS_X     = 3'd0;
   localparam logic [AXIS_BITS-1:0] AXIS_Y     = 3'd1;
   localparam logic [AXIS_BITS-1:0] AXIS_Z     = 3'd2;
   localparam logic [AXIS_BITS-1:0] AXIS_NEG_X = 3'd3;
   localparam logic [AXIS_BITS-1:0] AXIS_NEG_Y = 3'd4;

   // fixed-point arithmetic
   localparam int RATIO_BITS     = 16;
   localparam int RATIO_SHIFT    = 24;
   localparam int RQ_OFFSET      = 256;
   localparam int SQRT_ARG_BITS  = 50;
   localparam int SQRT_ROOT_BITS = SQRT_ARG_BITS / 2;
   localparam int ONE_MINUS_BITS = 34;
   localparam int CORDIC_BITS    = 28;
   localparam int ACC_BITS       = 19;
   localparam int ACC_MAG_BITS   = 17;
   localparam int CORDIC_PASSES  = 16;
   localparam int PASS_BITS      = 4;
   localparam int SCALE_BITS     = 13;
   localparam int PROD_BITS      = ACC_MAG_BITS + SCALE_BITS + 1;

   localparam logic [SCALE_BITS-1:0] SCALE_CENTIDEG = 13'd5729;
   localparam logic [ANGLE_BITS-1:0] ANGLE_MAX      = 14'd9000;

   // reciprocal constants for division by 100 and by 10
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam logic [7:0]  RECIP_10  = 8'd205;
   localparam logic [6:0]  HUNDRED   = 7'd100;
   localparam logic [3:0]  TEN       = 4'd10;

   typedef enum logic [2:0] {
      FR_IDLE,
      FR_SQUARE,
      FR_SUM,
      FR_START,
      FR_ROOT,
      FR_PUSH
   } front_state_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_AXIS,
      BK_DIV,
      BK_SQUARE,
      BK_START,
      BK_ROOT,
      BK_CORDIC,
      BK_SCALE,
      BK_SPLIT,
      BK_FRAC,
      BK_DIGIT,
      BK_EMIT
   } back_state_type;

   // atan(2^-i) in Q16 radians
   function automatic logic [15:0] atan_q16(input logic [PASS_BITS-1:0] pass);
      logic [15:0] value;
      case (pass)
         4'd0:    value = 16'd51472;
         4'd1:    value = 16'd30386;
         4'd2:    value = 16'd16055;
         4'd3:    value = 16'd8150;
         4'd4:    value = 16'd4091;
         4'd5:    value = 16'd2047;
         4'd6:    value = 16'd1024;
         4'd7:    value = 16'd512;
         4'd8:    value = 16'd256;
         4'd9:    value = 16'd128;
         4'd10:   value = 16'd64;
         4'd11:   value = 16'd32;
         4'd12:   value = 16'd16;
         4'd13:   value = 16'd8;
         4'd14:   value = 16'd4;
         default: value = 16'd2;
      endcase
      return value;
   endfunction

   // active-low seven-segment codes
   function automatic logic [SEG_BITS-1:0] seg_code(input logic [DIGIT_BITS-1:0] digit);
      logic [SEG_BITS-1:0] code;
      case (digit)
         4'd0:    code = 8'hC0;
         4'd1:    code = 8'hF9;
         4'd2:    code = 8'hA4;
         4'd3:    code = 8'hB0;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h92;
         4'd6:    code = 8'h82;
         4'd7:    code = 8'hF8;
         4'd8:    code = 8'h80;
         4'd9:    code = 8'h90;
         default: code = 8'hC0;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

@@ rtl/svs_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface svs_req_if #(parameter int SAMPLE_BITS = 10);
   logic                   valid;
   logic                   ready;
   logic [SAMPLE_BITS-1:0] sample_x;
   logic [SAMPLE_BITS-1:0] sample_y;
   logic [SAMPLE_BITS-1:0] sample_z;
   logic [SAMPLE_BITS-1:0] sample_neg_x;
   logic [SAMPLE_BITS-1:0] sample_neg_y;

   modport source (
      output valid, sample_x, sample_y, sample_z, sample_neg_x, sample_neg_y,
      input  ready
   );

   modport sink (
      input  valid, sample_x, sample_y, sample_z, sample_neg_x, sample_neg_y,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/svs_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface svs_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  axis;
   logic [13:0] angle_centideg;
   logic [7:0]  seg_int_tens;
   logic [7:0]  seg_int_ones;
   logic [7:0]  seg_frac_tens;
   logic [7:0]  seg_frac_ones;
   logic        last;

   modport source (
      output valid, axis, angle_centideg, seg_int_tens, seg_int_ones,
             seg_frac_tens, seg_frac_ones, last,
      input  ready
   );

   modport sink (
      input  valid, axis, angle_centideg, seg_int_tens, seg_int_ones,
             seg_frac_tens, seg_frac_ones, last,
      output ready
   );
endinterface

`default_nettype wire

@@ rtl/svs_isqrt.sv @@
`timescale 1ns / 1ps
`default_nettype none

module svs_isqrt #(
   parameter int VAL_BITS = 50
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [VAL_BITS-1:0]   value,
   output logic                  done,
   output logic [VAL_BITS/2-1:0] root
);

   localparam int ROOT_BITS = VAL_BITS / 2;
   localparam int CNT_BITS  = $clog2(ROOT_BITS);
   localparam logic [CNT_BITS-1:0] LAST_STEP = CNT_BITS'(ROOT_BITS - 1);

   logic [VAL_BITS-1:0]  val_ff;
   logic [ROOT_BITS+1:0] rem_ff;
   logic [ROOT_BITS-1:0] root_ff;
   logic [CNT_BITS-1:0]  cnt_ff;
   logic                 busy_ff;
   logic                 done_ff;

   logic [ROOT_BITS+3:0] cand;
   logic [ROOT_BITS+3:0] trial;
   logic [ROOT_BITS+3:0] diff;
   logic                 fits;

   // one root bit per cycle, two radicand bits shifted in
   always_comb begin
      cand  = {rem_ff, val_ff[VAL_BITS-1 -: 2]};
      trial = {2'b00, root_ff, 2'b01};
      diff  = cand - trial;
      fits  = (cand >= trial);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (cnt_ff == LAST_STEP)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (start) begin
         val_ff  <= value;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= '0;
      end else if (busy_ff) begin
         val_ff  <= {val_ff[VAL_BITS-3:0], 2'b00};
         rem_ff  <= fits ? diff[ROOT_BITS+1:0] : cand[ROOT_BITS+1:0];
         root_ff <= {root_ff[ROOT_BITS-2:0], fits};
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

`default_nettype wire

@@ rtl/svs_front.sv @@
`timescale 1ns / 1ps
`default_nettype none

module svs_front
   import svs_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [SAMPLE_BITS-1:0]   req_sample_x,
   input  logic [SAMPLE_BITS-1:0]   req_sample_y,
   input  logic [SAMPLE_BITS-1:0]   req_sample_z,
   input  logic [SAMPLE_BITS-1:0]   req_sample_neg_x,
   input  logic [SAMPLE_BITS-1:0]   req_sample_neg_y,
   output logic                     push_valid,
   input  logic                     push_ready,
   output logic [5*SAMPLE_BITS+SAMPLE_BITS+10:0] push_data
);

   localparam int SET_BITS  = 5 * SAMPLE_BITS;
   localparam int PAIR_BITS = SAMPLE_BITS + 1;
   localparam int SQ_BITS   = 2 * PAIR_BITS;
   localparam int SUM_BITS  = 2 * SAMPLE_BITS + 4;
   localparam int ARG_BITS  = SUM_BITS + 16;
   localparam int ROOT_BITS = ARG_BITS / 2;
   localparam int RQ_BITS   = ROOT_BITS + 1;

   front_state_type state_ff, state_in;

   logic                hold_valid_ff;
   logic [SET_BITS-1:0] hold_ff;
   logic [SET_BITS-1:0] set_ff;
   logic [SQ_BITS-1:0]  sq_x_ff, sq_y_ff, sq_z_ff;
   logic [SUM_BITS-1:0] sum_ff;
   logic [RQ_BITS-1:0]  rq_ff;

   logic                 take;
   logic                 root_start;
   logic                 root_done;
   logic [ROOT_BITS-1:0] root;
   logic [PAIR_BITS-1:0] pair_x, pair_y, pair_z;

   // input holding register frees the request side while the root runs
   assign req_ready = !hold_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         hold_valid_ff <= 1'b1;
      end else if (take) begin
         hold_valid_ff <= 1'b0;
      end
      if (req_valid && req_ready) begin
         hold_ff <= {req_sample_neg_y, req_sample_neg_x, req_sample_z,
                     req_sample_y, req_sample_x};
      end
   end

   // opposite faces combined
   always_comb begin
      pair_x = {1'b0, set_ff[0 +: SAMPLE_BITS]} +
               {1'b0, set_ff[3*SAMPLE_BITS +: SAMPLE_BITS]};
      pair_y = {1'b0, set_ff[SAMPLE_BITS +: SAMPLE_BITS]} +
               {1'b0, set_ff[4*SAMPLE_BITS +: SAMPLE_BITS]};
      pair_z = {1'b0, set_ff[2*SAMPLE_BITS +: SAMPLE_BITS]};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE:   if (hold_valid_ff) state_in = FR_SQUARE;
         FR_SQUARE: state_in = FR_SUM;
         FR_SUM:    state_in = FR_START;
         FR_START:  state_in = FR_ROOT;
         FR_ROOT:   if (root_done) state_in = FR_PUSH;
         FR_PUSH:   if (push_ready) state_in = FR_IDLE;
         default:   state_in = FR_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      take       = 1'b0;
      root_start = 1'b0;
      push_valid = 1'b0;
      unique case (state_ff)
         FR_IDLE:  take       = hold_valid_ff;
         FR_START: root_start = 1'b1;
         FR_PUSH:  push_valid = 1'b1;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // squares, sum and magnitude
   always_ff @(posedge clock) begin
      if (take) begin
         set_ff <= hold_ff;
      end
      if (state_ff == FR_SQUARE) begin
         sq_x_ff <= pair_x * pair_x;
         sq_y_ff <= pair_y * pair_y;
         sq_z_ff <= pair_z * pair_z;
      end
      if (state_ff == FR_SUM) begin
         sum_ff <= SUM_BITS'(sq_x_ff) + SUM_BITS'(sq_y_ff) + SUM_BITS'(sq_z_ff);
      end
      if (root_done) begin
         rq_ff <= {1'b0, root} + RQ_BITS'(RQ_OFFSET);
      end
   end

   svs_isqrt #(.VAL_BITS(ARG_BITS)) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value ({sum_ff, 16'h0000}),
      .done  (root_done),
      .root  (root)
   );

   assign push_data = {rq_ff, set_ff};

endmodule

`default_nettype wire

@@ rtl/svs_queue.sv @@
`timescale 1ns / 1ps
`default_nettype none

module svs_queue #(
   parameter int DATA_BITS = 71
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   output logic                 push_ready,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 pop_valid,
   input  logic                 pop_ready,
   output logic [DATA_BITS-1:0] pop_data
);

   logic [DATA_BITS-1:0] entry_ff [2];
   logic                 wr_ptr_ff;
   logic                 rd_ptr_ff;
   logic [1:0]           count_ff;
   logic                 push;
   logic                 pop;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_data   = entry_ff[rd_ptr_ff];

   // two-entry ring between front and back
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop)  rd_ptr_ff <= !rd_ptr_ff;
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

@@ rtl/svs_back.sv @@
`timescale 1ns / 1ps
`default_nettype none

module svs_back
   import svs_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    pop_valid,
   output logic                    pop_ready,
   input  logic [5*SAMPLE_BITS+SAMPLE_BITS+10:0] pop_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [AXIS_BITS-1:0]    rsp_axis,
   output logic [ANGLE_BITS-1:0]   rsp_angle_centideg,
   output logic [SEG_BITS-1:0]     rsp_seg_int_tens,
   output logic [SEG_BITS-1:0]     rsp_seg_int_ones,
   output logic [SEG_BITS-1:0]     rsp_seg_frac_tens,
   output logic [SEG_BITS-1:0]     rsp_seg_frac_ones,
   output logic                    rsp_last
);

   localparam int SET_BITS = 5 * SAMPLE_BITS;
   localparam int RQ_BITS  = SAMPLE_BITS + 11;
   localparam int NUM_BITS = SAMPLE_BITS + RATIO_SHIFT;
   localparam int CNT_BITS = $clog2(NUM_BITS);
   localparam logic [CNT_BITS-1:0] DIV_LAST = CNT_BITS'(NUM_BITS - 1);
   localparam logic [PASS_BITS-1:0] PASS_LAST = PASS_BITS'(CORDIC_PASSES - 1);

   back_state_type state_ff, state_in;

   logic [SET_BITS-1:0]    set_ff;
   logic [RQ_BITS-1:0]     rq_ff;
   logic [AXIS_BITS-1:0]   axis_ff;

   logic [NUM_BITS-1:0]    num_ff;
   logic [NUM_BITS-1:0]    quo_ff;
   logic [RQ_BITS-1:0]     rem_ff;
   logic [CNT_BITS-1:0]    cnt_ff;

   logic [RATIO_BITS-1:0]     q_ff;
   logic [2*RATIO_BITS-1:0]   qq_ff;

   logic signed [CORDIC_BITS-1:0] x_ff, y_ff;
   logic signed [ACC_BITS-1:0]    a_ff;
   logic [PASS_BITS-1:0]          pass_ff;

   logic [PROD_BITS-1:0]   prod_ff;
   logic [ANGLE_BITS-1:0]  ang_ff;
   logic [6:0]             whole_ff;
   logic [6:0]             frac_ff;

   logic                   out_valid_ff;
   logic [AXIS_BITS-1:0]   out_axis_ff;
   logic [ANGLE_BITS-1:0]  out_angle_ff;
   logic [SEG_BITS-1:0]    out_seg_ff [4];
   logic [SEG_BITS-1:0]    seg_ff [4];

   logic                   root_start;
   logic                   root_done;
   logic [SQRT_ROOT_BITS-1:0] root;
   logic                   emit;

   logic [SAMPLE_BITS-1:0] sample_sel;
   logic [RQ_BITS:0]       div_cand;
   logic [RQ_BITS:0]       div_diff;
   logic                   div_fits;
   logic [RATIO_BITS-1:0]  q_clamp;
   logic [ONE_MINUS_BITS-1:0] one_minus;
   logic signed [CORDIC_BITS-1:0] dx, dy;
   logic signed [ACC_BITS-1:0]    da;
   logic [ACC_MAG_BITS-1:0]       a_mag;
   logic [PROD_BITS-17:0]  ang_raw;
   logic [ANGLE_BITS-1:0]  ang_lim;
   logic [26:0]            whole_prod;
   logic [14:0]            it_prod, ft_prod;
   logic [DIGIT_BITS-1:0]  it_dig, io_dig, ft_dig, fo_dig;

   // sample of the current axis
   always_comb begin
      case (axis_ff)
         AXIS_X:     sample_sel = set_ff[0 +: SAMPLE_BITS];
         AXIS_Y:     sample_sel = set_ff[SAMPLE_BITS +: SAMPLE_BITS];
         AXIS_Z:     sample_sel = set_ff[2*SAMPLE_BITS +: SAMPLE_BITS];
         AXIS_NEG_X: sample_sel = set_ff[3*SAMPLE_BITS +: SAMPLE_BITS];
         default:    sample_sel = set_ff[4*SAMPLE_BITS +: SAMPLE_BITS];
      endcase
   end

   // restoring divider step
   always_comb begin
      div_cand = {rem_ff, num_ff[NUM_BITS-1]};
      div_diff = div_cand - {1'b0, rq_ff};
      div_fits = (div_cand >= {1'b0, rq_ff});
   end

   // ratio clamp and sqrt argument
   always_comb begin
      q_clamp   = (|quo_ff[NUM_BITS-1:RATIO_BITS]) ? '1 : quo_ff[RATIO_BITS-1:0];
      one_minus = (ONE_MINUS_BITS'(1) << 32) - ONE_MINUS_BITS'(qq_ff);
   end

   // cordic micro-rotation
   always_comb begin
      dx = y_ff >>> pass_ff;
      dy = x_ff >>> pass_ff;
      da = ACC_BITS'(atan_q16(pass_ff));
   end

   // scaling and decimal split
   always_comb begin
      a_mag      = a_ff[ACC_BITS-1] ? '0 : a_ff[ACC_MAG_BITS-1:0];
      ang_raw    = prod_ff[PROD_BITS-1:16];
      ang_lim    = (ang_raw > {1'b0, ANGLE_MAX}) ? ANGLE_MAX : ang_raw[ANGLE_BITS-1:0];
      whole_prod = ang_ff * RECIP_100;
      it_prod    = whole_ff * RECIP_10;
      ft_prod    = frac_ff * RECIP_10;
      it_dig     = it_prod[14:11];
      ft_dig     = ft_prod[14:11];
      io_dig     = DIGIT_BITS'(whole_ff - 7'(it_dig * TEN));
      fo_dig     = DIGIT_BITS'(frac_ff - 7'(ft_dig * TEN));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE:   if (pop_valid) state_in = BK_AXIS;
         BK_AXIS:   state_in = BK_DIV;
         BK_DIV:    if (cnt_ff == DIV_LAST) state_in = BK_SQUARE;
         BK_SQUARE: state_in = BK_START;
         BK_START:  state_in = BK_ROOT;
         BK_ROOT:   if (root_done) state_in = BK_CORDIC;
         BK_CORDIC: if (pass_ff == PASS_LAST) state_in = BK_SCALE;
         BK_SCALE:  state_in = BK_SPLIT;
         BK_SPLIT:  state_in = BK_FRAC;
         BK_FRAC:   state_in = BK_DIGIT;
         BK_DIGIT:  state_in = BK_EMIT;
         BK_EMIT: begin
            if (emit) state_in = (axis_ff == AXIS_NEG_Y) ? BK_IDLE : BK_AXIS;
         end
         default:   state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop_ready  = 1'b0;
      root_start = 1'b0;
      emit       = 1'b0;
      unique case (state_ff)
         BK_IDLE:  pop_ready  = 1'b1;
         BK_START: root_start = 1'b1;
         BK_EMIT:  emit       = !out_valid_ff || rsp_ready;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (state_ff == BK_IDLE && pop_valid) begin
         set_ff  <= pop_data[SET_BITS-1:0];
         rq_ff   <= pop_data[SET_BITS +: RQ_BITS];
         axis_ff <= AXIS_X;
      end
      if (state_ff == BK_AXIS) begin
         num_ff <= {sample_sel, {RATIO_SHIFT{1'b0}}};
         quo_ff <= '0;
         rem_ff <= '0;
         cnt_ff <= '0;
      end
      if (state_ff == BK_DIV) begin
         num_ff <= {num_ff[NUM_BITS-2:0], 1'b0};
         quo_ff <= {quo_ff[NUM_BITS-2:0], div_fits};
         rem_ff <= div_fits ? div_diff[RQ_BITS-1:0] : div_cand[RQ_BITS-1:0];
         cnt_ff <= cnt_ff + 1'b1;
      end
      if (state_ff == BK_SQUARE) begin
         q_ff  <= q_clamp;
         qq_ff <= q_clamp * q_clamp;
      end
      if (root_done) begin
         x_ff    <= CORDIC_BITS'({q_ff, 8'h00});
         y_ff    <= CORDIC_BITS'(root);
         a_ff    <= '0;
         pass_ff <= '0;
      end
      if (state_ff == BK_CORDIC) begin
         if (!y_ff[CORDIC_BITS-1]) begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            a_ff <= a_ff + da;
         end else begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            a_ff <= a_ff - da;
         end
         pass_ff <= pass_ff + 1'b1;
      end
      if (state_ff == BK_SCALE) begin
         prod_ff <= PROD_BITS'(a_mag * SCALE_CENTIDEG);
      end
      if (state_ff == BK_SPLIT) begin
         ang_ff <= ang_lim;
      end
      if (state_ff == BK_FRAC) begin
         whole_ff <= whole_prod[25:19];
         frac_ff  <= 7'(ang_ff - ANGLE_BITS'(whole_prod[25:19] * HUNDRED));
      end
      if (state_ff == BK_DIGIT) begin
         seg_ff[0] <= seg_code(it_dig);
         seg_ff[1] <= seg_code(io_dig);
         seg_ff[2] <= seg_code(ft_dig);
         seg_ff[3] <= seg_code(fo_dig);
      end
      if (emit) begin
         axis_ff <= axis_ff + 1'b1;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (emit) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
      if (emit) begin
         out_axis_ff  <= axis_ff;
         out_angle_ff <= ang_ff;
         out_seg_ff   <= seg_ff;
      end
   end

   svs_isqrt #(.VAL_BITS(SQRT_ARG_BITS)) u_isqrt (
      .clock (clock),
      .reset (reset),
      .start (root_start),
      .value ({one_minus, 16'h0000}),
      .done  (root_done),
      .root  (root)
   );

   assign rsp_valid          = out_valid_ff;
   assign rsp_axis           = out_axis_ff;
   assign rsp_angle_centideg = out_angle_ff;
   assign rsp_seg_int_tens   = out_seg_ff[0];
   assign rsp_seg_int_ones   = out_seg_ff[1];
   assign rsp_seg_frac_tens  = out_seg_ff[2];
   assign rsp_seg_frac_ones  = out_seg_ff[3];
   assign rsp_last           = (out_axis_ff == AXIS_NEG_Y);

endmodule

`default_nettype wire

@@ rtl/sun_vector_angle_to_segments_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Sun vector angle core.
// req channel: one request carries the five light-sensor levels
// (plus x, plus y, plus z, minus x, minus y), SAMPLE_BITS each.
// rsp channel: five results per request, in axis order 0..4, each with
// the angle in hundredths of a degree and four active-low segment codes;
// last is set on the fifth.
// The front takes a request into a holding register, forms the squared
// magnitude and its root and queues the set.
// The back computes each axis in turn: a radix-2 divider, a square root,
// 16 CORDIC passes, then scaling and decimal split.
// A finished result waits in an output register; while rsp stalls the back
// holds; the front accepts until the two-entry queue and holding reg fill.
// Reset empties the holding register, the queue and the output register.
module sun_vector_angle_to_segments_core
   import svs_pkg::*;
#(
   parameter int SAMPLE_BITS = 10
) (
   input  wire logic clock,
   input  wire logic reset,
   svs_req_if.sink   req,
   svs_rsp_if.source rsp
);

   localparam int QUEUE_BITS = 6 * SAMPLE_BITS + 11;

   logic                  push_valid;
   logic                  push_ready;
   logic [QUEUE_BITS-1:0] push_data;
   logic                  pop_valid;
   logic                  pop_ready;
   logic [QUEUE_BITS-1:0] pop_data;

   // front: intake and magnitude
   svs_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req.valid),
      .req_ready        (req.ready),
      .req_sample_x     (req.sample_x),
      .req_sample_y     (req.sample_y),
      .req_sample_z     (req.sample_z),
      .req_sample_neg_x (req.sample_neg_x),
      .req_sample_neg_y (req.sample_neg_y),
      .push_valid       (push_valid),
      .push_ready       (push_ready),
      .push_data        (push_data)
   );

   svs_queue #(.DATA_BITS(QUEUE_BITS)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // back: per-axis angle and segments
   svs_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
      .clock              (clock),
      .reset              (reset),
      .pop_valid          (pop_valid),
      .pop_ready          (pop_ready),
      .pop_data           (pop_data),
      .rsp_valid          (rsp.valid),
      .rsp_ready          (rsp.ready),
      .rsp_axis           (rsp.axis),
      .rsp_angle_centideg (rsp.angle_centideg),
      .rsp_seg_int_tens   (rsp.seg_int_tens),
      .rsp_seg_int_ones   (rsp.seg_int_ones),
      .rsp_seg_frac_tens  (rsp.seg_frac_tens),
      .rsp_seg_frac_ones  (rsp.seg_frac_ones),
      .rsp_last           (rsp.last)
   );

endmodule

`default_nettype wire

@@ rtl/svs_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module svs_checker
   import svs_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [AXIS_BITS-1:0]  rsp_axis,
   input wire logic [ANGLE_BITS-1:0] rsp_angle_centideg,
   input wire logic                  rsp_last
);

   // a stalled result holds its angle
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_angle_centideg))
      else $error("stalled result changed");

   // nothing offered right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // last only on the fifth axis
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_axis == AXIS_NEG_Y)))
      else $error("last flag does not match axis");

   // angle limited and axes follow in order
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last ##1 rsp_valid
         |-> rsp_axis == $past(rsp_axis) + 3'd1 && rsp_angle_centideg <= ANGLE_MAX)
      else $error("axis order or angle range broken");

endmodule

bind sun_vector_angle_to_segments_core svs_checker u_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_axis           (rsp.axis),
   .rsp_angle_centideg (rsp.angle_centideg),
   .rsp_last           (rsp.last)
);

`default_nettype wire
